[rtl/gradient_bandit_agent_core_assert.svh]
// Assertion macros used by the checker file.
`ifndef GRADIENT_BANDIT_AGENT_CORE_ASSERT_SVH
`define GRADIENT_BANDIT_AGENT_CORE_ASSERT_SVH

// Same-cycle implication, reset-qualified.
`define GBA_ASSERT_IMPL(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error("assertion failed");

// Next-cycle implication, reset-qualified.
`define GBA_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error("assertion failed");

`endif

[rtl/gba_pkg.sv]
// ----------------------------------------------------------------------------
// gba_pkg
// Types, constants and helper functions of the gradient bandit agent.
// ----------------------------------------------------------------------------
package gba_pkg;

	localparam int NUM_ARMS  = 16;
	localparam int ARM_W     = $clog2(NUM_ARMS);
	localparam int STEP_W    = 20;
	localparam int PREF_W    = 32;
	localparam int PROB_W    = 17;
	localparam int REG_IDX_W = 1;
	localparam int WR_W      = 16;

	// Serial divider sizes: dividend, divisor, iteration counter
	localparam int DIV_NW = 33;
	localparam int DIV_DW = 21;
	localparam int DIV_CW = $clog2(DIV_NW);

	localparam logic [16:0] LOG2E_Q16 = 17'd94548;
	localparam logic [16:0] PROB_ONE  = 17'd65536;

	// Item kinds
	localparam logic [1:0] ACT_CHOOSE  = 2'd0;
	localparam logic [1:0] ACT_REWARD  = 2'd1;
	localparam logic [1:0] ACT_RESTART = 2'd2;

	// Register indexes
	localparam logic [REG_IDX_W-1:0] REG_STEP_SIZE = 1'd0;
	localparam logic [REG_IDX_W-1:0] REG_ARMS      = 1'd1;

	localparam logic [15:0] STEP_SIZE_RST = 16'd6554;
	localparam logic [4:0]  ARMS_RST      = 5'd10;

	// Datapath operations issued by the controller
	typedef enum logic [3:0] {
		OP_IDLE,
		OP_MAX,
		OP_EXP_MUL,
		OP_EXP_ACC,
		OP_DIV_GO,
		OP_DIV_WAIT,
		OP_SAMPLE,
		OP_BASE_GO,
		OP_BASE_WAIT,
		OP_DELTA,
		OP_UPD_MUL,
		OP_UPD_APPLY,
		OP_CLEAR,
		OP_DONE
	} op_t;

	typedef struct packed {
		logic             accept;
		op_t              op;
		logic [ARM_W-1:0] idx;
	} cmd_t;

	typedef struct packed {
		logic div_done;
		logic hit;
		logic idx_last;
	} stat_t;

	// 2^(-k/16) in Q1.16
	function automatic logic [16:0] pow2_frac(input logic [3:0] k);
		logic [16:0] v;
		case (k)
			4'd0:    v = 17'd65536;
			4'd1:    v = 17'd62757;
			4'd2:    v = 17'd60097;
			4'd3:    v = 17'd57549;
			4'd4:    v = 17'd55110;
			4'd5:    v = 17'd52773;
			4'd6:    v = 17'd50535;
			4'd7:    v = 17'd48393;
			4'd8:    v = 17'd46341;
			4'd9:    v = 17'd44376;
			4'd10:   v = 17'd42495;
			4'd11:   v = 17'd40693;
			4'd12:   v = 17'd38968;
			4'd13:   v = 17'd37316;
			4'd14:   v = 17'd35734;
			default: v = 17'd34219;
		endcase
		return v;
	endfunction

	// Saturate a 36-bit signed value to int32
	function automatic logic signed [31:0] sat32(input logic signed [35:0] v);
		logic signed [31:0] r;
		if (v > 36'sh0_7FFF_FFFF)
			r = 32'sh7FFF_FFFF;
		else if (v < -36'sh0_8000_0000)
			r = 32'sh8000_0000;
		else
			r = v[31:0];
		return r;
	endfunction

endpackage

[rtl/gba_div.sv]
// ----------------------------------------------------------------------------
// gba_div
// Unsigned restoring divider, one quotient bit per cycle.
// ----------------------------------------------------------------------------
module gba_div import gba_pkg::*; (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              start,
	input  logic [DIV_NW-1:0] num,
	input  logic [DIV_DW-1:0] den,
	output logic              done,
	output logic [DIV_NW-1:0] quo
);

	logic              busy_q;
	logic [DIV_CW-1:0] cnt_q;
	logic [DIV_DW-1:0] rem_q;
	logic [DIV_DW-1:0] den_q;
	logic [DIV_NW-1:0] quo_q;
	logic              done_q;
	logic [DIV_DW:0]   sh;
	logic [DIV_DW:0]   diff;
	logic              ge;

	// Trial subtract
	assign sh   = {rem_q, quo_q[DIV_NW-1]};
	assign diff = sh - {1'b0, den_q};
	assign ge   = (sh >= {1'b0, den_q});

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			cnt_q  <= '0;
			done_q <= 1'b0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				busy_q <= 1'b1;
				cnt_q  <= DIV_CW'(DIV_NW - 1);
			end else if (busy_q) begin
				if (cnt_q == '0) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
				cnt_q <= cnt_q - 1'b1;
			end
		end
	end

	// Payload: remainder and quotient shift
	always_ff @(posedge clk) begin
		if (start) begin
			rem_q <= '0;
			quo_q <= num;
			den_q <= den;
		end else if (busy_q) begin
			rem_q <= ge ? diff[DIV_DW-1:0] : sh[DIV_DW-1:0];
			quo_q <= {quo_q[DIV_NW-2:0], ge};
		end
	end

	assign done = done_q;
	assign quo  = quo_q;

endmodule

[rtl/gba_datapath.sv]
// ----------------------------------------------------------------------------
// gba_datapath
// Preference, probability and baseline storage with the arithmetic units.
// ----------------------------------------------------------------------------
module gba_datapath import gba_pkg::*; (
	input  logic                 clk,
	input  logic                 arst_n,
	input  cmd_t                 cmd,
	output stat_t                stat,
	input  logic [1:0]           action,
	input  logic [15:0]          uniform_draw,
	input  logic signed [15:0]   reward,
	input  logic                 wr_en,
	input  logic [REG_IDX_W-1:0] wr_index,
	input  logic [WR_W-1:0]      wr_data,
	output logic                 done,
	output logic [1:0]           item_kind,
	output logic [3:0]           chosen_arm,
	output logic [16:0]          chosen_prob,
	output logic signed [15:0]   baseline_value
);

	logic [15:0]              step_size_q;
	logic [4:0]               arms_in_use_q;
	logic signed [PREF_W-1:0] pref_q [NUM_ARMS];
	logic [PROB_W-1:0]        prob_q [NUM_ARMS];
	logic [PROB_W-1:0]        e_q    [NUM_ARMS];
	logic signed [31:0]       base_q;
	logic [STEP_W-1:0]        steps_q;
	logic [ARM_W-1:0]         last_arm_q;
	logic [PROB_W-1:0]        cprob_q;
	logic [1:0]               kind_q;
	logic [15:0]              draw_q;
	logic signed [15:0]       rew_q;
	logic signed [31:0]       max_q;
	logic [20:0]              sum_q;
	logic [17:0]              cum_q;
	logic [32:0]              y_q;
	logic [48:0]              ma_q;
	logic                     neg_q;
	logic                     dneg_q;
	logic [33:0]              t_q;
	logic                     done_q;
	logic [1:0]               okind_q;
	logic [3:0]               oarm_q;
	logic [16:0]              oprob_q;
	logic [15:0]              obase_q;

	logic [4:0]               n_act;
	logic [ARM_W-1:0]         nlast;
	logic signed [31:0]       pref_i;
	logic [PROB_W-1:0]        prob_i;
	logic [32:0]              dmax;
	logic [48:0]              ymul;
	logic [16:0]              ip;
	logic [16:0]              e_c;
	logic [17:0]              cum_c;
	logic [STEP_W-1:0]        steps_inc;
	logic signed [32:0]       rq33;
	logic signed [32:0]       base33;
	logic signed [32:0]       diff;
	logic [32:0]              mag;
	logic                     div_start;
	logic [DIV_NW-1:0]        div_num;
	logic [DIV_DW-1:0]        div_den;
	logic                     div_done;
	logic [DIV_NW-1:0]        div_quo;
	logic signed [33:0]       q34;
	logic signed [31:0]       base_new;
	logic                     is_last;
	logic [16:0]              pcl;
	logic [16:0]              xsel;
	logic [65:0]              prod;
	logic signed [35:0]       tt;
	logic signed [35:0]       upd;
	logic signed [31:0]       pref_new;

	// Active arm count, clamped
	always_comb begin
		if (arms_in_use_q < 5'd2)
			n_act = 5'd2;
		else if (arms_in_use_q > 5'(NUM_ARMS))
			n_act = 5'(NUM_ARMS);
		else
			n_act = arms_in_use_q;
	end
	assign nlast = ARM_W'(n_act - 5'd1);

	assign pref_i = pref_q[cmd.idx];
	assign prob_i = prob_q[cmd.idx];

	// Exponential: d * log2(e), then table and shift
	assign dmax = {max_q[31], max_q} - {pref_i[31], pref_i};
	assign ymul = dmax[31:0] * LOG2E_Q16;
	assign ip   = y_q[32:16];
	assign e_c  = (ip >= 17'd17) ? '0 : (pow2_frac(y_q[15:12]) >> ip[4:0]);

	assign cum_c = cum_q + {1'b0, prob_i};

	// Baseline difference against the scaled reward
	assign steps_inc = (steps_q == '1) ? steps_q : steps_q + 1'b1;
	assign rq33      = 33'($signed({rew_q, 8'h00}));
	assign base33    = 33'(base_q);
	assign diff      = rq33 - base33;
	assign mag       = diff[32] ? 33'(-diff) : diff;

	// Divider operand select
	assign div_start = (cmd.op == OP_DIV_GO) || (cmd.op == OP_BASE_GO);
	assign div_num   = (cmd.op == OP_BASE_GO) ? mag : {e_q[cmd.idx], 16'h0000};
	assign div_den   = (cmd.op == OP_BASE_GO) ? {1'b0, steps_inc} : sum_q;

	gba_div u_div (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (div_start),
		.num    (div_num),
		.den    (div_den),
		.done   (div_done),
		.quo    (div_quo)
	);

	assign q34      = dneg_q ? -$signed({1'b0, div_quo}) : $signed({1'b0, div_quo});
	assign base_new = sat32(36'(base_q) + 36'(q34));

	// Preference update terms
	assign is_last  = (cmd.idx == last_arm_q);
	assign pcl      = (prob_i > PROB_ONE) ? PROB_ONE : prob_i;
	assign xsel     = is_last ? (PROB_ONE - pcl) : prob_i;
	assign prod     = ma_q * xsel;
	assign tt       = neg_q ? -$signed({2'b00, t_q}) : $signed({2'b00, t_q});
	assign upd      = is_last ? tt : -tt;
	assign pref_new = sat32(36'(pref_i) + upd);

	assign stat.div_done = div_done;
	assign stat.hit      = ({2'b00, draw_q} < cum_c);
	assign stat.idx_last = (cmd.idx == nlast);

	// Configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			step_size_q   <= STEP_SIZE_RST;
			arms_in_use_q <= ARMS_RST;
		end else if (wr_en) begin
			case (wr_index)
				REG_STEP_SIZE: step_size_q   <= wr_data;
				REG_ARMS:      arms_in_use_q <= wr_data[4:0];
				default: ;
			endcase
		end
	end

	// Agent state and output registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < NUM_ARMS; i++)
				pref_q[i] <= '0;
			base_q     <= '0;
			steps_q    <= '0;
			last_arm_q <= '0;
			cprob_q    <= '0;
			kind_q     <= '0;
			done_q     <= 1'b0;
			okind_q    <= '0;
			oarm_q     <= '0;
			oprob_q    <= '0;
			obase_q    <= '0;
		end else begin
			done_q <= 1'b0;
			if (cmd.accept)
				kind_q <= action;
			case (cmd.op)
				OP_SAMPLE: begin
					if (stat.hit || stat.idx_last) begin
						last_arm_q <= cmd.idx;
						cprob_q    <= prob_i;
					end
				end
				OP_BASE_GO:
					steps_q <= steps_inc;
				OP_BASE_WAIT: begin
					if (div_done)
						base_q <= base_new;
				end
				OP_UPD_APPLY:
					pref_q[cmd.idx] <= pref_new;
				OP_CLEAR: begin
					for (int i = 0; i < NUM_ARMS; i++)
						pref_q[i] <= '0;
					base_q     <= '0;
					steps_q    <= '0;
					last_arm_q <= '0;
					cprob_q    <= '0;
				end
				OP_DONE: begin
					done_q  <= 1'b1;
					okind_q <= kind_q;
					oarm_q  <= 4'(last_arm_q);
					oprob_q <= cprob_q;
					obase_q <= base_q[23:8];
				end
				default: ;
			endcase
		end
	end

	// Working registers, no reset needed
	always_ff @(posedge clk) begin
		if (cmd.accept) begin
			draw_q <= uniform_draw;
			rew_q  <= reward;
			max_q  <= pref_q[0];
			sum_q  <= '0;
			cum_q  <= '0;
		end
		case (cmd.op)
			OP_MAX: begin
				if (pref_i > max_q)
					max_q <= pref_i;
			end
			OP_EXP_MUL:
				y_q <= ymul[48:16];
			OP_EXP_ACC: begin
				e_q[cmd.idx] <= e_c;
				sum_q        <= sum_q + 21'(e_c);
			end
			OP_DIV_WAIT: begin
				if (div_done)
					prob_q[cmd.idx] <= div_quo[PROB_W-1:0];
			end
			OP_SAMPLE:
				cum_q <= cum_c;
			OP_BASE_GO:
				dneg_q <= diff[32];
			OP_DELTA: begin
				neg_q <= diff[32];
				ma_q  <= mag * step_size_q;
			end
			OP_UPD_MUL:
				t_q <= prod[65:32];
			default: ;
		endcase
	end

	assign done           = done_q;
	assign item_kind      = okind_q;
	assign chosen_arm     = oarm_q;
	assign chosen_prob    = oprob_q;
	assign baseline_value = obase_q;

endmodule

[rtl/gba_ctrl.sv]
// ----------------------------------------------------------------------------
// gba_ctrl
// Sequencer: runs the phases of a choose, reward or restart item, walking the arms in each per-arm phase.
// ----------------------------------------------------------------------------
module gba_ctrl import gba_pkg::*; (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       start,
	input  logic [1:0] action,
	input  stat_t      stat,
	output cmd_t       cmd,
	output logic       busy
);

	typedef enum logic [3:0] {
		S_IDLE,
		S_MAX,
		S_EXP_MUL,
		S_EXP_ACC,
		S_DIV_GO,
		S_DIV_WAIT,
		S_SAMPLE,
		S_BASE_GO,
		S_BASE_WAIT,
		S_DELTA,
		S_UPD_MUL,
		S_UPD_APPLY,
		S_CLEAR,
		S_DONE
	} state_t;

	state_t           state_q;
	logic [ARM_W-1:0] idx_q;
	logic             busy_q;
	logic             accept;

	assign accept = start && !busy_q;

	// Operation decode
	always_comb begin
		cmd.accept = accept;
		cmd.idx    = idx_q;
		case (state_q)
			S_MAX:       cmd.op = OP_MAX;
			S_EXP_MUL:   cmd.op = OP_EXP_MUL;
			S_EXP_ACC:   cmd.op = OP_EXP_ACC;
			S_DIV_GO:    cmd.op = OP_DIV_GO;
			S_DIV_WAIT:  cmd.op = OP_DIV_WAIT;
			S_SAMPLE:    cmd.op = OP_SAMPLE;
			S_BASE_GO:   cmd.op = OP_BASE_GO;
			S_BASE_WAIT: cmd.op = OP_BASE_WAIT;
			S_DELTA:     cmd.op = OP_DELTA;
			S_UPD_MUL:   cmd.op = OP_UPD_MUL;
			S_UPD_APPLY: cmd.op = OP_UPD_APPLY;
			S_CLEAR:     cmd.op = OP_CLEAR;
			S_DONE:      cmd.op = OP_DONE;
			default:     cmd.op = OP_IDLE;
		endcase
	end

	// State, arm index and busy flag
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			idx_q   <= '0;
			busy_q  <= 1'b0;
		end else begin
			case (state_q)
				S_IDLE: begin
					idx_q <= '0;
					if (accept) begin
						busy_q <= 1'b1;
						case (action)
							ACT_CHOOSE:  state_q <= S_MAX;
							ACT_REWARD:  state_q <= S_BASE_GO;
							ACT_RESTART: state_q <= S_CLEAR;
							default:     state_q <= S_DONE;
						endcase
					end
				end
				S_MAX: begin
					if (stat.idx_last) begin
						idx_q   <= '0;
						state_q <= S_EXP_MUL;
					end else
						idx_q <= idx_q + 1'b1;
				end
				S_EXP_MUL:
					state_q <= S_EXP_ACC;
				S_EXP_ACC: begin
					if (stat.idx_last) begin
						idx_q   <= '0;
						state_q <= S_DIV_GO;
					end else begin
						idx_q   <= idx_q + 1'b1;
						state_q <= S_EXP_MUL;
					end
				end
				S_DIV_GO:
					state_q <= S_DIV_WAIT;
				S_DIV_WAIT: begin
					if (stat.div_done) begin
						if (stat.idx_last) begin
							idx_q   <= '0;
							state_q <= S_SAMPLE;
						end else begin
							idx_q   <= idx_q + 1'b1;
							state_q <= S_DIV_GO;
						end
					end
				end
				S_SAMPLE: begin
					if (stat.hit || stat.idx_last)
						state_q <= S_DONE;
					else
						idx_q <= idx_q + 1'b1;
				end
				S_BASE_GO:
					state_q <= S_BASE_WAIT;
				S_BASE_WAIT: begin
					if (stat.div_done)
						state_q <= S_DELTA;
				end
				S_DELTA: begin
					idx_q   <= '0;
					state_q <= S_UPD_MUL;
				end
				S_UPD_MUL:
					state_q <= S_UPD_APPLY;
				S_UPD_APPLY: begin
					if (stat.idx_last)
						state_q <= S_DONE;
					else begin
						idx_q   <= idx_q + 1'b1;
						state_q <= S_UPD_MUL;
					end
				end
				S_CLEAR:
					state_q <= S_DONE;
				S_DONE: begin
					busy_q  <= 1'b0;
					state_q <= S_IDLE;
				end
				default: begin
					busy_q  <= 1'b0;
					state_q <= S_IDLE;
				end
			endcase
		end
	end

	assign busy = busy_q;

endmodule

[rtl/gradient_bandit_agent_core.sv]
// ----------------------------------------------------------------------------
// gradient_bandit_agent_core
// Softmax gradient bandit agent: choose, reward and restart items.
// ----------------------------------------------------------------------------
// Channel   Signals                                 Handshake
// input     action, uniform_draw, reward            start high, busy low
// result    item_kind, chosen_arm, chosen_prob,     done, one cycle
//           baseline_value
// config    wr_index, wr_data                       wr_en
//
// One item at a time: busy falls at the edge that raises done. A choose item
// finds the largest preference, forms the exponentials, divides each by their
// sum in the serial divider and scans arms in sampling; a reward item runs one
// divide, then a multiply and an update step per arm; restart clears the state
// and an unknown kind goes straight to the result. Reset clears preferences,
// baseline and counters at once. The result side cannot stall.
// ----------------------------------------------------------------------------
module gradient_bandit_agent_core import gba_pkg::*; (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 start,
	output logic                 busy,
	input  logic [1:0]           action,
	input  logic [15:0]          uniform_draw,
	input  logic signed [15:0]   reward,
	input  logic                 wr_en,
	input  logic [REG_IDX_W-1:0] wr_index,
	input  logic [WR_W-1:0]      wr_data,
	output logic                 done,
	output logic [1:0]           item_kind,
	output logic [3:0]           chosen_arm,
	output logic [16:0]          chosen_prob,
	output logic signed [15:0]   baseline_value
);

	cmd_t  cmd;
	stat_t stat;

	gba_ctrl u_ctrl (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (start),
		.action (action),
		.stat   (stat),
		.cmd    (cmd),
		.busy   (busy)
	);

	gba_datapath u_dp (
		.clk            (clk),
		.arst_n         (arst_n),
		.cmd            (cmd),
		.stat           (stat),
		.action         (action),
		.uniform_draw   (uniform_draw),
		.reward         (reward),
		.wr_en          (wr_en),
		.wr_index       (wr_index),
		.wr_data        (wr_data),
		.done           (done),
		.item_kind      (item_kind),
		.chosen_arm     (chosen_arm),
		.chosen_prob    (chosen_prob),
		.baseline_value (baseline_value)
	);

endmodule

[rtl/gba_checker.sv]
// ----------------------------------------------------------------------------
// gba_checker
// Port-level checks of the agent core, bound to the top level.
// ----------------------------------------------------------------------------
`include "gradient_bandit_agent_core_assert.svh"

module gba_checker import gba_pkg::*; (
	input logic                 clk,
	input logic                 arst_n,
	input logic                 start,
	input logic                 busy,
	input logic                 done,
	input logic [1:0]           item_kind,
	input logic [3:0]           chosen_arm,
	input logic [16:0]          chosen_prob,
	input logic signed [15:0]   baseline_value
);

	// An accepted item holds off further items
	`GBA_ASSERT_NEXT(a_busy_after_accept, clk, arst_n, start && !busy, busy)

	// No result in the cycle right after an accept
	`GBA_ASSERT_NEXT(a_no_early_done, clk, arst_n, start && !busy, !done)

	// One result per item: the done strobe is never repeated back to back
	`GBA_ASSERT_NEXT(a_done_single, clk, arst_n, done, !done)

	// A restart result shows cleared state
	`GBA_ASSERT_IMPL(a_restart_clear, clk, arst_n, done && (item_kind == ACT_RESTART),
		(chosen_arm == 4'd0) && (chosen_prob == 17'd0) && (baseline_value == 16'sd0))

endmodule

bind gradient_bandit_agent_core gba_checker u_gba_checker (
	.clk            (clk),
	.arst_n         (arst_n),
	.start          (start),
	.busy           (busy),
	.done           (done),
	.item_kind      (item_kind),
	.chosen_arm     (chosen_arm),
	.chosen_prob    (chosen_prob),
	.baseline_value (baseline_value)
);
